// ===== rtl/core/srt_pkg.sv =====
// Shared types and codes of the sorted record table.
package srt_pkg;

  localparam int DEPTH_DEFAULT    = 32;
  localparam int KEY_BITS_DEFAULT = 40;

  localparam int KEY_W     = 40;
  localparam int PAYLOAD_W = 64;
  localparam int COUNT_W   = 6;
  localparam int FUNC_W    = 2;
  localparam int STATUS_W  = 2;

  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_LIST   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [COUNT_W-1:0]   entry_count;
    logic [KEY_W-1:0]     out_key;
    logic [PAYLOAD_W-1:0] out_payload;
    logic                 last;
  } result_t;

endpackage

// ===== rtl/core/srt_mem.sv =====
// Record storage: key and payload arrays, one write port, one registered read port.
module srt_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5,
  parameter int KW    = 40,
  parameter int PW    = 64
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [KW-1:0] wkey,
  input  logic [PW-1:0] wpayload,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [KW-1:0] rkey,
  output logic [PW-1:0] rpayload
);

  logic [KW-1:0] key_mem     [DEPTH];
  logic [PW-1:0] payload_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[waddr]     <= wkey;
      payload_mem[waddr] <= wpayload;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rkey     <= key_mem[raddr];
      rpayload <= payload_mem[raddr];
    end
  end

endmodule

// ===== rtl/core/srt_ctrl.sv =====
// Command sequencer: scans, shifts and lists records through the storage port.
module srt_ctrl #(
  parameter int DEPTH = 32,
  parameter int AW    = 5,
  parameter int CW    = 6,
  parameter int KW    = 40
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cmd_valid,
  output logic                           cmd_ready,
  input  logic [srt_pkg::FUNC_W-1:0]     cmd_func,
  input  logic [srt_pkg::KEY_W-1:0]      cmd_key,
  input  logic [srt_pkg::PAYLOAD_W-1:0]  cmd_payload,
  output logic                           res_valid,
  input  logic                           res_ready,
  output srt_pkg::result_t               res,
  output logic                           we,
  output logic [AW-1:0]                  waddr,
  output logic [KW-1:0]                  wkey,
  output logic [srt_pkg::PAYLOAD_W-1:0]  wpayload,
  output logic                           re,
  output logic [AW-1:0]                  raddr,
  input  logic [KW-1:0]                  rkey,
  input  logic [srt_pkg::PAYLOAD_W-1:0]  rpayload
);
  import srt_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_IRD   = 4'd1;
  localparam logic [3:0] S_ICMP  = 4'd2;
  localparam logic [3:0] S_IWR   = 4'd3;
  localparam logic [3:0] S_DRD   = 4'd4;
  localparam logic [3:0] S_DCMP  = 4'd5;
  localparam logic [3:0] S_SRD   = 4'd6;
  localparam logic [3:0] S_SWR   = 4'd7;
  localparam logic [3:0] S_LRD   = 4'd8;
  localparam logic [3:0] S_LEMIT = 4'd9;
  localparam logic [3:0] S_EMIT  = 4'd10;

  logic [3:0]           state, state_next;
  logic [CW-1:0]        fill, fill_next;
  logic [CW-1:0]        idx, idx_next;
  logic [STATUS_W-1:0]  stat, stat_next;
  logic [KW-1:0]        key_r;
  logic [PAYLOAD_W-1:0] payload_r;

  logic [CW-1:0] idx_m1, idx_p1, idx_p2;
  logic [63:0]   key_wide_in;
  logic [63:0]   key_wide_out;
  logic [7:0]    fill_wide;
  logic          accept;

  assign idx_m1       = idx - CW'(1);
  assign idx_p1       = idx + CW'(1);
  assign idx_p2       = idx + CW'(2);
  assign key_wide_in  = {{(64 - KEY_W){1'b0}}, cmd_key};
  assign key_wide_out = 64'(rkey);
  assign fill_wide    = 8'(fill);
  assign cmd_ready    = (state == S_IDLE);
  assign accept       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
      idx   <= '0;
      stat  <= ST_OK;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      idx   <= idx_next;
      stat  <= stat_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_r     <= key_wide_in[KW-1:0];
      payload_r <= cmd_payload;
    end
  end

  always_comb begin
    state_next = state;
    fill_next  = fill;
    idx_next   = idx;
    stat_next  = stat;
    we         = 1'b0;
    waddr      = idx[AW-1:0];
    wkey       = rkey;
    wpayload   = rpayload;
    re         = 1'b0;
    raddr      = idx[AW-1:0];
    res_valid  = 1'b0;
    res.status      = stat;
    res.entry_count = fill_wide[COUNT_W-1:0];
    res.out_key     = '0;
    res.out_payload = '0;
    res.last        = 1'b1;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          case (cmd_func)
            FUNC_INSERT: begin
              if (fill == CW'(DEPTH)) begin
                stat_next  = ST_FULL;
                state_next = S_EMIT;
              end else begin
                idx_next   = fill;
                state_next = (fill == '0) ? S_IWR : S_IRD;
              end
            end
            FUNC_DELETE: begin
              if (fill == '0) begin
                stat_next  = ST_EMPTY;
                state_next = S_EMIT;
              end else begin
                idx_next   = '0;
                state_next = S_DRD;
              end
            end
            FUNC_LIST: begin
              if (fill == '0) begin
                stat_next  = ST_EMPTY;
                state_next = S_EMIT;
              end else begin
                idx_next   = '0;
                state_next = S_LRD;
              end
            end
            default: ;
          endcase
        end
      end
      S_IRD: begin
        re         = 1'b1;
        raddr      = idx_m1[AW-1:0];
        state_next = S_ICMP;
      end
      S_ICMP: begin
        // move the record below up one slot while it is not smaller
        if (key_r > rkey) begin
          state_next = S_IWR;
        end else begin
          we       = 1'b1;
          idx_next = idx_m1;
          state_next = (idx_m1 == '0) ? S_IWR : S_IRD;
        end
      end
      S_IWR: begin
        we         = 1'b1;
        wkey       = key_r;
        wpayload   = payload_r;
        fill_next  = fill + CW'(1);
        stat_next  = ST_OK;
        state_next = S_EMIT;
      end
      S_DRD: begin
        re         = 1'b1;
        state_next = S_DCMP;
      end
      S_DCMP: begin
        if (rkey == key_r) begin
          if (idx_p1 < fill) begin
            state_next = S_SRD;
          end else begin
            fill_next  = fill - CW'(1);
            stat_next  = ST_OK;
            state_next = S_EMIT;
          end
        end else if (idx_p1 == fill) begin
          stat_next  = ST_NOT_FOUND;
          state_next = S_EMIT;
        end else begin
          idx_next   = idx_p1;
          state_next = S_DRD;
        end
      end
      S_SRD: begin
        re         = 1'b1;
        raddr      = idx_p1[AW-1:0];
        state_next = S_SWR;
      end
      S_SWR: begin
        // close the gap one record at a time
        we       = 1'b1;
        idx_next = idx_p1;
        if (idx_p2 < fill) begin
          state_next = S_SRD;
        end else begin
          fill_next  = fill - CW'(1);
          stat_next  = ST_OK;
          state_next = S_EMIT;
        end
      end
      S_LRD: begin
        re         = 1'b1;
        state_next = S_LEMIT;
      end
      S_LEMIT: begin
        res_valid       = 1'b1;
        res.status      = ST_OK;
        res.out_key     = key_wide_out[KEY_W-1:0];
        res.out_payload = rpayload;
        res.last        = (idx_p1 == fill);
        if (res_ready) begin
          if (idx_p1 == fill) begin
            state_next = S_IDLE;
          end else begin
            idx_next   = idx_p1;
            state_next = S_LRD;
          end
        end
      end
      S_EMIT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/sorted_record_table_core.sv =====
// Top level of the sorted record table: stream ports, storage and result register.
//
// Holds up to DEPTH records (key and 64-bit payload) in ascending key order in
// a single-port-write, registered-read memory. Each request is one command
// (insert, delete by key, list). Records are visited one at a time through the
// memory port, a read then a compare or write, so the timing is set by the
// number of records touched: an insert by the records it moves up one slot,
// a delete, found or not, or a list by all records held. A full-table insert
// and an empty-table delete or list touch no record, and a result side that
// holds off stalls the sequencer. A new request is taken only after the
// previous command has handed over its last result; the result register lets
// the next request enter while that result still waits downstream. Unknown
// func codes are dropped without a result. Keys are kept to their low KEY_BITS
// bits. No clearing pass is needed after reset: only entries below the fill
// level are ever read.
module sorted_record_table_core #(
  parameter int DEPTH    = srt_pkg::DEPTH_DEFAULT,
  parameter int KEY_BITS = srt_pkg::KEY_BITS_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [103:0] s_tdata,   // key[39:0], payload[103:40]
  input  logic [1:0]   s_tuser,   // func[1:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [111:0] m_tdata,   // entry_count[5:0], out_key[45:6], out_payload[109:46], zero
  output logic [1:0]   m_tuser,   // status[1:0]
  output logic         m_tlast    // last result of the request
);
  import srt_pkg::*;

  // storage geometry follows from the parameters
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;

  logic                 we, re;
  logic [AW-1:0]        waddr, raddr;
  logic [KW-1:0]        wkey, rkey;
  logic [PAYLOAD_W-1:0] wpayload, rpayload;
  logic                 res_valid, res_ready;
  result_t              res;
  result_t              out_r;

  // the sequencer never reads and writes in the same cycle, so no forwarding
  srt_mem #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .KW    (KW),
    .PW    (PAYLOAD_W)
  ) u_mem (
    .clk      (clk),
    .we       (we),
    .waddr    (waddr),
    .wkey     (wkey),
    .wpayload (wpayload),
    .re       (re),
    .raddr    (raddr),
    .rkey     (rkey),
    .rpayload (rpayload)
  );

  srt_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW),
    .KW    (KW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (s_tvalid),
    .cmd_ready   (s_tready),
    .cmd_func    (s_tuser),
    .cmd_key     (s_tdata[39:0]),
    .cmd_payload (s_tdata[103:40]),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .we          (we),
    .waddr       (waddr),
    .wkey        (wkey),
    .wpayload    (wpayload),
    .re          (re),
    .raddr       (raddr),
    .rkey        (rkey),
    .rpayload    (rpayload)
  );

  // result register: load when empty or being drained
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign m_tdata = {2'b00, out_r.out_payload, out_r.out_key, out_r.entry_count};
  assign m_tuser = out_r.status;
  assign m_tlast = out_r.last;

endmodule

// ===== test/sorted_record_table_checker.sv =====
// Checker for the sorted record table: predicts results from accepted requests and compares.
module sorted_record_table_checker #(
  parameter int DEPTH    = srt_pkg::DEPTH_DEFAULT,
  parameter int KEY_BITS = srt_pkg::KEY_BITS_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [103:0] s_tdata,   // key[39:0], payload[103:40]
  input  logic [1:0]   s_tuser,   // func[1:0]
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [111:0] m_tdata,   // entry_count[5:0], out_key[45:6], out_payload[109:46], zero
  input  logic [1:0]   m_tuser,   // status[1:0]
  input  logic         m_tlast,
  output int           mismatch_count,
  output int           pending_results
);

  timeunit 1ns;
  timeprecision 1ps;

  import srt_pkg::*;

  localparam logic [KEY_W-1:0] KEY_MASK =
    (KEY_BITS >= KEY_W) ? {KEY_W{1'b1}} : ((({{(KEY_W-1){1'b0}}, 1'b1}) << KEY_BITS) - 1'b1);

  // Shadow copy of the table, ascending by key.
  logic [KEY_W-1:0]     rec_keys     [DEPTH];
  logic [PAYLOAD_W-1:0] rec_payloads [DEPTH];
  int                   rec_fill;
  result_t              awaited_results [$];

  task automatic report_mismatch(input string what, input logic [127:0] got,
                                 input logic [127:0] want);
    $display("%0t: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic push_result(input logic [STATUS_W-1:0] status,
                             input logic [KEY_W-1:0] key,
                             input logic [PAYLOAD_W-1:0] payload, input logic last);
    result_t r;
    r.status      = status;
    r.entry_count = rec_fill[COUNT_W-1:0];
    r.out_key     = key;
    r.out_payload = payload;
    r.last        = last;
    awaited_results.push_back(r);
  endtask

  // Apply one command to the shadow table and queue the results it causes.
  task automatic apply_command(input logic [FUNC_W-1:0] func, input logic [KEY_W-1:0] raw_key,
                               input logic [PAYLOAD_W-1:0] payload);
    logic [KEY_W-1:0] key;
    int pos;
    key = raw_key & KEY_MASK;
    pos = 0;
    case (func)
      FUNC_INSERT: begin
        if (rec_fill >= DEPTH) begin
          push_result(ST_FULL, '0, '0, 1'b1);
        end else begin
          // new record goes in front of any equal keys
          while (pos < rec_fill && key > rec_keys[pos]) pos++;
          for (int i = rec_fill; i > pos; i--) begin
            rec_keys[i]     = rec_keys[i-1];
            rec_payloads[i] = rec_payloads[i-1];
          end
          rec_keys[pos]     = key;
          rec_payloads[pos] = payload;
          rec_fill++;
          push_result(ST_OK, '0, '0, 1'b1);
        end
      end
      FUNC_DELETE: begin
        if (rec_fill == 0) begin
          push_result(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          while (pos < rec_fill && rec_keys[pos] != key) pos++;
          if (pos >= rec_fill) begin
            push_result(ST_NOT_FOUND, '0, '0, 1'b1);
          end else begin
            for (int i = pos; i + 1 < rec_fill; i++) begin
              rec_keys[i]     = rec_keys[i+1];
              rec_payloads[i] = rec_payloads[i+1];
            end
            rec_fill--;
            push_result(ST_OK, '0, '0, 1'b1);
          end
        end
      end
      FUNC_LIST: begin
        if (rec_fill == 0) begin
          push_result(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          for (int i = 0; i < rec_fill; i++)
            push_result(ST_OK, rec_keys[i], rec_payloads[i], i + 1 == rec_fill);
        end
      end
      default: ;  // unused code: dropped by the block
    endcase
  endtask

  task automatic check_result();
    result_t got;
    result_t want;
    got.status      = m_tuser;
    got.entry_count = m_tdata[5:0];
    got.out_key     = m_tdata[45:6];
    got.out_payload = m_tdata[109:46];
    got.last        = m_tlast;
    if (awaited_results.size() == 0) begin
      report_mismatch("result with nothing pending", got, '0);
      return;
    end
    want = awaited_results.pop_front();
    if (got.status !== want.status) report_mismatch("status", got.status, want.status);
    if (got.entry_count !== want.entry_count)
      report_mismatch("entry_count", got.entry_count, want.entry_count);
    if (got.out_key !== want.out_key) report_mismatch("out_key", got.out_key, want.out_key);
    if (got.out_payload !== want.out_payload)
      report_mismatch("out_payload", got.out_payload, want.out_payload);
    if (got.last !== want.last) report_mismatch("last", got.last, want.last);
  endtask

  // Results leave before new requests are predicted: a result taken at the
  // same edge as a request always belongs to an earlier request.
  always @(posedge clk) begin
    if (rst) begin
      rec_fill = 0;
      mismatch_count = 0;
      awaited_results.delete();
    end else begin
      if (m_tvalid && m_tready) check_result();
      if (s_tvalid && s_tready) apply_command(s_tuser, s_tdata[39:0], s_tdata[103:40]);
    end
    pending_results <= awaited_results.size();
  end

endmodule

// ===== test/sorted_record_table_core_tb.sv =====
// Testbench top of the sorted record table: stimulus, result backpressure and verdict.
module sorted_record_table_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import srt_pkg::*;

  localparam int TABLE_DEPTH    = 32;
  localparam int TABLE_KEY_BITS = 40;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no request or result taken
  localparam int LONG_HOLD      = 400;   // receiver hold-off that backs up the block
  localparam int DRAIN_CYCLES   = 120;   // covers the longest shift of a full table

  localparam logic [KEY_W-1:0]     KEY_TOP     = '1;
  localparam logic [PAYLOAD_W-1:0] PAYLOAD_TOP = '1;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [103:0] s_tdata = '0;  // key[39:0], payload[103:40]
  logic [1:0]   s_tuser = '0;  // func[1:0]
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [111:0] m_tdata;       // entry_count[5:0], out_key[45:6], out_payload[109:46], zero
  logic [1:0]   m_tuser;       // status[1:0]
  logic         m_tlast;

  int mismatch_count;
  int pending_results;

  logic tx_idle_en = 1'b1;
  logic rx_idle_en = 1'b1;
  logic long_hold_req = 1'b0;
  logic long_hold_done = 1'b0;
  int   stall_left = 0;
  int   quiet_cycles = 0;

  logic [KEY_W-1:0] key_pool [16];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  sorted_record_table_core #(
    .DEPTH   (TABLE_DEPTH),
    .KEY_BITS(TABLE_KEY_BITS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  sorted_record_table_checker #(
    .DEPTH   (TABLE_DEPTH),
    .KEY_BITS(TABLE_KEY_BITS)
  ) checker_i (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser),
    .m_tlast        (m_tlast),
    .mismatch_count (mismatch_count),
    .pending_results(pending_results)
  );

  // Result side: random stall bursts, plus one long hold-off on request so the
  // block fills its result register and stops taking requests.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_left != 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (long_hold_req && !long_hold_done) begin
      m_tready <= 1'b0;
      long_hold_done <= 1'b1;
      stall_left <= LONG_HOLD - 1;
    end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
      m_tready <= 1'b0;
      stall_left <= $urandom_range(0, 11);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Watchdog: end the run if nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Offer one request and hold it until the block takes it; an optional idle
  // burst goes in front of it.
  task automatic send_request(input logic [FUNC_W-1:0] func, input logic [KEY_W-1:0] key,
                              input logic [PAYLOAD_W-1:0] payload);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {payload, key};
    do @(posedge clk); while (!s_tready);
  endtask

  function automatic logic [PAYLOAD_W-1:0] random_payload();
    return {$urandom(), $urandom()};
  endfunction

  // Mostly pool keys so duplicates and hits on delete are common.
  function automatic logic [KEY_W-1:0] pick_key();
    logic [63:0] wide;
    wide = {$urandom(), $urandom()};
    if ($urandom_range(0, 3) != 0) return key_pool[$urandom_range(0, 15)];
    return wide[KEY_W-1:0];
  endfunction

  function automatic logic [FUNC_W-1:0] pick_func(input int ins_w, input int del_w,
                                                  input int list_w);
    int r;
    r = $urandom_range(0, 99);
    if (r < ins_w) return FUNC_INSERT;
    if (r < ins_w + del_w) return FUNC_DELETE;
    if (r < ins_w + del_w + list_w) return FUNC_LIST;
    return FUNC_UNUSED;
  endfunction

  // Random phase: count only requests the block acts on.
  task automatic random_phase(input int n_items, input int ins_w, input int del_w,
                              input int list_w, input int hold_at);
    logic [FUNC_W-1:0] func;
    int done_items;
    done_items = 0;
    while (done_items < n_items) begin
      func = pick_func(ins_w, del_w, list_w);
      if (done_items == hold_at) long_hold_req <= 1'b1;
      send_request(func, pick_key(), random_payload());
      if (func != FUNC_UNUSED) done_items++;
    end
  endtask

  initial begin
    key_pool[0] = '0;
    key_pool[1] = KEY_TOP;
    for (int i = 2; i < 16; i++) key_pool[i] = {$urandom(), 8'($urandom())};
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty table, ignored code, extremes, duplicates, misses.
    send_request(FUNC_LIST, 40'd7, 64'd9);
    send_request(FUNC_DELETE, 40'd5, '0);
    send_request(FUNC_UNUSED, KEY_TOP, PAYLOAD_TOP);
    send_request(FUNC_INSERT, KEY_TOP, PAYLOAD_TOP);
    send_request(FUNC_INSERT, '0, '0);
    send_request(FUNC_INSERT, 40'd100, 64'hA);
    send_request(FUNC_INSERT, 40'd100, 64'hB);
    send_request(FUNC_INSERT, 40'd100, 64'hC);
    send_request(FUNC_LIST, '0, '0);
    send_request(FUNC_DELETE, 40'd100, '0);   // front-most duplicate goes
    send_request(FUNC_DELETE, 40'd55, '0);    // absent key
    send_request(FUNC_UNUSED, pick_key(), random_payload());
    send_request(FUNC_LIST, KEY_TOP, PAYLOAD_TOP);
    send_request(FUNC_DELETE, KEY_TOP, '0);
    send_request(FUNC_DELETE, '0, '0);
    send_request(FUNC_DELETE, 40'd100, '0);
    send_request(FUNC_DELETE, 40'd100, '0);
    send_request(FUNC_LIST, '0, '0);
    send_request(FUNC_DELETE, 40'd100, '0);
    send_request(FUNC_INSERT, 40'h55_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    send_request(FUNC_INSERT, 40'hAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
    send_request(FUNC_LIST, '0, '0);

    // Fill until the table rejects inserts; one long receiver hold-off.
    random_phase(65, 75, 12, 10, 15);
    // Drain with mostly deletes.
    random_phase(50, 15, 65, 15, -1);
    // Last stretch without idling on either side.
    tx_idle_en = 1'b0;
    rx_idle_en <= 1'b0;
    random_phase(35, 40, 35, 20, -1);

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sorted_record_table_core.f =====
rtl/core/srt_pkg.sv
rtl/core/srt_mem.sv
rtl/core/srt_ctrl.sv
rtl/core/sorted_record_table_core.sv
test/sorted_record_table_checker.sv
test/sorted_record_table_core_tb.sv
